>>> src/prefix_expression_evaluator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PREFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define PREFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Types and constants shared by the prefix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;
    typedef logic [7:0] t_symbol;
    typedef logic [2:0] t_status;
    typedef logic [1:0] t_alu_op;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_UNDER = 3'd1;
    localparam t_status ST_OVER  = 3'd2;
    localparam t_status ST_DIVZ  = 3'd3;
    localparam t_status ST_BAD   = 3'd4;
    localparam t_status ST_LEFT  = 3'd5;

    localparam t_symbol CH_0     = 8'h30;
    localparam t_symbol CH_9     = 8'h39;
    localparam t_symbol CH_PLUS  = 8'h2B;
    localparam t_symbol CH_MINUS = 8'h2D;
    localparam t_symbol CH_MUL   = 8'h2A;
    localparam t_symbol CH_DIV   = 8'h2F;
    localparam t_symbol CH_POW   = 8'h5E;

    localparam t_alu_op OP_MUL = 2'd0;
    localparam t_alu_op OP_DIV = 2'd1;
    localparam t_alu_op OP_POW = 2'd2;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;

    typedef struct packed {
        logic done;
        logic divz;
    } t_alu_rsp;

    typedef struct packed {
        logic shift_down;  // take the entry above (push)
        logic shift_up;    // take the entry below (pop)
    } t_cell_ctl;
endpackage

>>> src/pee_sym_if.sv
// ----------------------------------------------------------------------------
// pee_sym_if
// Symbol channel: valid/ready with one symbol and an end marker.
// ----------------------------------------------------------------------------
interface pee_sym_if import pee_pkg::*; ;
    logic    valid;
    logic    ready;
    t_symbol symbol;
    logic    last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

>>> src/pee_res_if.sv
// ----------------------------------------------------------------------------
// pee_res_if
// Result channel: valid/ready with the final value and status.
// ----------------------------------------------------------------------------
interface pee_res_if import pee_pkg::*; ;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    t_status     status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

>>> src/prefix_expression_evaluator_unit.sv
// Digits, + and - update the stack directly; *, / and ^ wait in S_BUSY for the ALU,
// and ^ runs as repeated products on the shared shift-add multiplier.
// The symbol marked last leads to S_FIN, which places the result in the output register.
// One symbol is in work at a time; the next is taken when the unit is back in S_IDLE,
// after the ALU is free. Reset clears the count, status and handshakes; stack cells are not cleared.
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_unit
// Prefix expression evaluator over a chain of stack cells with a multicycle ALU.
// ----------------------------------------------------------------------------
`include "prefix_expression_evaluator_unit_assert.svh"
module prefix_expression_evaluator_unit import pee_pkg::*; #(
    parameter int STACK_DEPTH = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pee_sym_if.sink   i_sym,
    pee_res_if.source o_res
);
    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_status          r_err, n_err;
    logic             r_last, n_last;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_value, n_out_value;
    t_status          r_out_status, n_out_status;

    logic [W-1:0] w_cell [STACK_DEPTH];
    logic [W-1:0] w_top_new;
    logic         w_push, w_pop;
    t_alu_cmd     w_cmd;
    t_alu_rsp     w_rsp;
    logic [W-1:0] w_alu_res;
    logic         w_acc;
    logic         w_digit;
    logic         w_arith;
    logic signed [W-1:0] w_top;

    assign w_acc   = i_sym.valid && i_sym.ready;
    assign w_digit = (i_sym.symbol >= CH_0) && (i_sym.symbol <= CH_9);
    assign w_arith = (i_sym.symbol == CH_PLUS) || (i_sym.symbol == CH_MINUS)
                  || (i_sym.symbol == CH_MUL) || (i_sym.symbol == CH_DIV)
                  || (i_sym.symbol == CH_POW);
    assign w_top   = (r_cnt == '0) ? '0 : w_cell[0];

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_err        = r_err;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_push       = 1'b0;
        w_pop        = 1'b0;
        w_top_new    = '0;
        w_cmd.start  = 1'b0;
        w_cmd.op     = OP_MUL;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_last = i_sym.last;
                    n_state = i_sym.last ? S_FIN : S_IDLE;
                    if (w_digit) begin
                        if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                            n_err = (r_err == ST_OK) ? ST_OVER : r_err;
                        end else begin
                            w_push = 1'b1;
                            w_top_new = W'(i_sym.symbol[3:0]);
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end else if (w_arith) begin
                        if (r_cnt < CNT_W'(2)) begin
                            n_err = (r_err == ST_OK) ? ST_UNDER : r_err;
                        end else if (i_sym.symbol == CH_PLUS) begin
                            w_pop = 1'b1;
                            w_top_new = w_cell[0] + w_cell[1];
                            n_cnt = r_cnt - CNT_W'(1);
                        end else if (i_sym.symbol == CH_MINUS) begin
                            w_pop = 1'b1;
                            w_top_new = w_cell[0] - w_cell[1];
                            n_cnt = r_cnt - CNT_W'(1);
                        end else begin
                            w_cmd.start = 1'b1;
                            if (i_sym.symbol == CH_MUL) begin
                                w_cmd.op = OP_MUL;
                            end else if (i_sym.symbol == CH_DIV) begin
                                w_cmd.op = OP_DIV;
                            end else begin
                                w_cmd.op = OP_POW;
                            end
                            n_state = S_BUSY;
                        end
                    end else begin
                        n_err = (r_err == ST_OK) ? ST_BAD : r_err;
                    end
                end
            end
            S_BUSY: begin
                if (w_rsp.done) begin
                    w_pop = 1'b1;
                    w_top_new = w_alu_res;
                    n_cnt = r_cnt - CNT_W'(1);
                    if (w_rsp.divz && (r_err == ST_OK)) begin
                        n_err = ST_DIVZ;
                    end
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = 32'(w_top);
                    n_out_status = r_err;
                    if (r_err == ST_OK) begin
                        if (r_cnt == '0) begin
                            n_out_status = ST_UNDER;
                        end else if (r_cnt > CNT_W'(1)) begin
                            n_out_status = ST_LEFT;
                        end
                    end
                    n_cnt = '0;
                    n_err = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // top of stack sits in cell 0; an operation pops two and pushes one
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        t_cell_ctl    w_ctl;
        logic [W-1:0] w_prev, w_next;
        if (i == 0) begin : g_head
            assign w_ctl.shift_down = w_push || w_pop;
            assign w_ctl.shift_up   = 1'b0;
            assign w_prev           = w_top_new;
        end else begin : g_body
            assign w_ctl.shift_down = w_push;
            assign w_ctl.shift_up   = w_pop;
            assign w_prev           = w_cell[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_cell[i+1];
        end
        pee_cell #(.W(W)) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_val  (w_cell[i])
        );
    end

    pee_alu #(.W(W)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_cell[0]),
        .i_b     (w_cell[1]),
        .o_rsp   (w_rsp),
        .o_res   (w_alu_res)
    );

    assign i_sym.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.status = r_out_status;

    `PEE_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(STACK_DEPTH))
    `PEE_ASSERT_IMP(a_start_operands, i_clk, i_rst_n, w_cmd.start, r_cnt >= CNT_W'(2))
    `PEE_ASSERT_IMP(a_clear_on_result, i_clk, i_rst_n, $rose(r_out_valid),
        (r_cnt == '0) && (r_err == ST_OK))
    `PEE_ASSERT_IMP(a_done_in_busy, i_clk, i_rst_n, w_rsp.done, r_state == S_BUSY)
endmodule

>>> src/pee_cell.sv
// ----------------------------------------------------------------------------
// pee_cell
// One stack entry; shifts toward the bottom on push, toward the top on pop.
// ----------------------------------------------------------------------------
module pee_cell import pee_pkg::*; #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  t_cell_ctl    i_ctl,
    input  logic [W-1:0] i_prev,
    input  logic [W-1:0] i_next,
    output logic [W-1:0] o_val
);
    logic [W-1:0] r_val;
    logic [W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift_down) begin
            n_val = i_prev;
        end else if (i_ctl.shift_up) begin
            n_val = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
endmodule

>>> src/pee_alu.sv
// ----------------------------------------------------------------------------
// pee_alu
// Multicycle multiply, divide and power on W-bit two's complement values.
// ----------------------------------------------------------------------------
`include "prefix_expression_evaluator_unit_assert.svh"
module pee_alu import pee_pkg::*; #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_alu_cmd     i_cmd,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_alu_rsp     o_rsp,
    output logic [W-1:0] o_res
);
    localparam int CW = $clog2(W + 1);
    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DIV  = 3'd2;
    localparam logic [2:0] A_POW  = 3'd3;
    localparam logic [2:0] A_DONE = 3'd4;
    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_ACC   = 2'd1;
    localparam logic [1:0] PH_SQ    = 2'd2;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_pcnt, n_pcnt;
    logic [W-1:0]  r_mc, n_mc, r_mp, n_mp, r_prod, n_prod;
    logic [W-1:0]  r_acc, n_acc, r_sq, n_sq, r_ex, n_ex;
    logic [W-1:0]  r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic [W-1:0]  r_res, n_res;
    logic          r_neg, n_neg, r_divz, n_divz;
    logic [W:0]    w_trial;
    logic [W-1:0]  w_mag_a, w_mag_b;

    assign w_mag_a = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign w_mag_b = i_b[W-1] ? (~i_b + W'(1)) : i_b;
    assign w_trial = {r_rem, r_quo[W-1]};

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_pcnt  = r_pcnt;
        n_mc    = r_mc;
        n_mp    = r_mp;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_sq    = r_sq;
        n_ex    = r_ex;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_res   = r_res;
        n_neg   = r_neg;
        n_divz  = r_divz;
        case (r_state)
            A_IDLE: begin
                n_divz = 1'b0;
                if (i_cmd.start) begin
                    case (i_cmd.op)
                        OP_MUL: begin
                            n_mc = i_a;
                            n_mp = i_b;
                            n_prod = '0;
                            n_cnt = '0;
                            n_phase = PH_PLAIN;
                            n_state = A_MUL;
                        end
                        OP_DIV: begin
                            if (i_b == '0) begin
                                n_res = '0;
                                n_divz = 1'b1;
                                n_state = A_DONE;
                            end else begin
                                n_rem = '0;
                                n_quo = w_mag_a;
                                n_dvs = w_mag_b;
                                n_neg = i_a[W-1] ^ i_b[W-1];
                                n_cnt = '0;
                                n_state = A_DIV;
                            end
                        end
                        OP_POW: begin
                            if (i_b[W-1]) begin
                                // negative exponent: only +1 and -1 survive
                                if (i_a == W'(1)) begin
                                    n_res = W'(1);
                                end else if (&i_a) begin
                                    n_res = i_b[0] ? '1 : W'(1);
                                end else begin
                                    n_res = '0;
                                end
                                n_state = A_DONE;
                            end else begin
                                n_acc = W'(1);
                                n_sq = i_a;
                                n_ex = i_b;
                                n_pcnt = '0;
                                n_state = A_POW;
                            end
                        end
                        default: begin
                            n_res = '0;
                            n_state = A_DONE;
                        end
                    endcase
                end
            end
            A_POW: begin
                n_cnt = '0;
                n_prod = '0;
                if (r_pcnt == CW'(W)) begin
                    n_res = r_acc;
                    n_state = A_DONE;
                end else if (r_ex[0]) begin
                    n_mc = r_acc;
                    n_mp = r_sq;
                    n_phase = PH_ACC;
                    n_state = A_MUL;
                end else begin
                    n_mc = r_sq;
                    n_mp = r_sq;
                    n_phase = PH_SQ;
                    n_state = A_MUL;
                end
            end
            A_MUL: begin
                if (r_cnt == CW'(W)) begin
                    n_cnt = '0;
                    case (r_phase)
                        PH_ACC: begin
                            n_acc = r_prod;
                            n_mc = r_sq;
                            n_mp = r_sq;
                            n_prod = '0;
                            n_phase = PH_SQ;
                        end
                        PH_SQ: begin
                            n_sq = r_prod;
                            n_ex = r_ex >> 1;
                            n_pcnt = r_pcnt + CW'(1);
                            n_state = A_POW;
                        end
                        default: begin
                            n_res = r_prod;
                            n_state = A_DONE;
                        end
                    endcase
                end else begin
                    if (r_mp[0]) begin
                        n_prod = r_prod + r_mc;
                    end
                    n_mc = r_mc << 1;
                    n_mp = r_mp >> 1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            A_DIV: begin
                if (r_cnt == CW'(W)) begin
                    n_res = r_neg ? (~r_quo + W'(1)) : r_quo;
                    n_state = A_DONE;
                end else begin
                    // restoring step, one quotient bit per cycle
                    n_quo = r_quo << 1;
                    if (w_trial >= {1'b0, r_dvs}) begin
                        n_rem = W'(w_trial - {1'b0, r_dvs});
                        n_quo[0] = 1'b1;
                    end else begin
                        n_rem = W'(w_trial);
                    end
                    n_cnt = r_cnt + CW'(1);
                end
            end
            A_DONE: begin
                n_divz = 1'b0;
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_divz  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_divz  <= n_divz;
        end
        r_phase <= n_phase;
        r_cnt   <= n_cnt;
        r_pcnt  <= n_pcnt;
        r_mc    <= n_mc;
        r_mp    <= n_mp;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_sq    <= n_sq;
        r_ex    <= n_ex;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_res   <= n_res;
        r_neg   <= n_neg;
    end

    assign o_rsp.done = (r_state == A_DONE);
    assign o_rsp.divz = r_divz;
    assign o_res      = r_res;

    `PEE_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_cmd.start, r_state == A_IDLE)
    `PEE_ASSERT_NXT(a_done_once, i_clk, i_rst_n, r_state == A_DONE, r_state == A_IDLE)
    `PEE_ASSERT_IMP(a_divz_done, i_clk, i_rst_n, r_divz, r_state == A_DONE)
endmodule
